[sv/spbm_pkg.sv]
// ----------------------------------------------------------------------------
// spbm_pkg
// Shared types, fixed-point constants and multiplier operand codes for the
// spring bar peak hold meter.
// ----------------------------------------------------------------------------
package spbm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int K_SIX     = ((6 << FRAC_BITS) + 5) / 10;
  localparam int K_TAIL    = ((22 << FRAC_BITS) + 50) / 100;
  localparam int TAIL_CAP  = ONE / 4;
  localparam int SPRING_K  = 576;
  localparam int DAMP_K    = 48;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_BOUNCE = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;
  localparam logic [1:0] REG_GRAV   = 2'd3;

  localparam logic [16:0] BOUNCE_RST = 17'd39322;
  localparam logic [15:0] STEP_RST   = 16'd1049;
  localparam logic [23:0] HOLD_RST   = 24'd22938;
  localparam logic [23:0] GRAV_RST   = 24'd161817;

  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_ZETA = 3'd0;
  localparam mul_sel_t MUL_DAMP = 3'd1;
  localparam mul_sel_t MUL_ACC  = 3'd2;
  localparam mul_sel_t MUL_VEL  = 3'd3;
  localparam mul_sel_t MUL_GRAV = 3'd4;
  localparam mul_sel_t MUL_PEAK = 3'd5;
  localparam mul_sel_t MUL_TAIL = 3'd6;

  typedef struct packed {
    logic [16:0] bounce;
    logic [15:0] step;
    logic [23:0] hold;
    logic [23:0] grav;
  } cfg_t;

  typedef struct packed {
    logic     ld_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_spr;
    logic     ld_zeta;
    logic     ld_acc;
    logic     ld_vel;
    logic     ld_bar;
    logic     ld_hold;
    logic     ld_pv;
    logic     ld_drop;
    logic     ld_snap;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic follow;
    logic expired;
  } status_t;

endpackage

[sv/spbm_cfg.sv]
// ----------------------------------------------------------------------------
// spbm_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module spbm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spbm_pkg::ADDR_W-1:0]  paddr,
  input  logic [spbm_pkg::DATA_W-1:0]  pwdata,
  output logic [spbm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output spbm_pkg::cfg_t               cfg
);
  import spbm_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bounce <= BOUNCE_RST;
      cfg.step   <= STEP_RST;
      cfg.hold   <= HOLD_RST;
      cfg.grav   <= GRAV_RST;
    end else if (wr) begin
      case (idx)
        REG_BOUNCE: cfg.bounce <= pwdata[16:0];
        REG_STEP:   cfg.step   <= pwdata[15:0];
        REG_HOLD:   cfg.hold   <= pwdata[23:0];
        REG_GRAV:   cfg.grav   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BOUNCE: prdata = {15'b0, cfg.bounce};
      REG_STEP:   prdata = {16'b0, cfg.step};
      REG_HOLD:   prdata = {8'b0, cfg.hold};
      REG_GRAV:   prdata = {8'b0, cfg.grav};
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/spbm_ctrl.sv]
// ----------------------------------------------------------------------------
// spbm_ctrl
// Sequencer: steps one transaction through the shared multiplier and owns
// both handshakes.
// ----------------------------------------------------------------------------
module spbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  output logic              meter_valid,
  input  logic              meter_stall,
  input  spbm_pkg::status_t status,
  output spbm_pkg::cmd_t    cmd
);
  import spbm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ZMUL = 5'd1;
  localparam logic [4:0] S_ZETA = 5'd2;
  localparam logic [4:0] S_DMUL = 5'd3;
  localparam logic [4:0] S_ACC  = 5'd4;
  localparam logic [4:0] S_AMUL = 5'd5;
  localparam logic [4:0] S_VEL  = 5'd6;
  localparam logic [4:0] S_VMUL = 5'd7;
  localparam logic [4:0] S_BAR  = 5'd8;
  localparam logic [4:0] S_HOLD = 5'd9;
  localparam logic [4:0] S_GMUL = 5'd10;
  localparam logic [4:0] S_PV   = 5'd11;
  localparam logic [4:0] S_PMUL = 5'd12;
  localparam logic [4:0] S_DROP = 5'd13;
  localparam logic [4:0] S_SNAP = 5'd14;
  localparam logic [4:0] S_TMUL = 5'd15;
  localparam logic [4:0] S_TAIL = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;

  assign sample_stall = (state != S_IDLE);
  assign out_free     = !meter_valid || !meter_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_ZMUL;
        end
      end
      S_ZMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ZETA;
        cmd.ld_spr  = 1'b1;
        state_next  = S_ZETA;
      end
      S_ZETA: begin
        cmd.ld_zeta = 1'b1;
        state_next  = S_DMUL;
      end
      S_DMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DAMP;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.ld_acc = 1'b1;
        state_next = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC;
        state_next  = S_VEL;
      end
      S_VEL: begin
        cmd.ld_vel = 1'b1;
        state_next = S_VMUL;
      end
      S_VMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL;
        state_next  = S_BAR;
      end
      S_BAR: begin
        cmd.ld_bar = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        cmd.ld_hold = 1'b1;
        if (!status.follow && status.expired) begin
          state_next = S_GMUL;
        end else begin
          state_next = S_TMUL;
        end
      end
      S_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GRAV;
        state_next  = S_PV;
      end
      S_PV: begin
        cmd.ld_pv  = 1'b1;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PEAK;
        state_next  = S_DROP;
      end
      S_DROP: begin
        cmd.ld_drop = 1'b1;
        state_next  = S_SNAP;
      end
      S_SNAP: begin
        cmd.ld_snap = 1'b1;
        state_next  = S_TMUL;
      end
      S_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TAIL;
        state_next  = S_TAIL;
      end
      S_TAIL: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      meter_valid <= 1'b0;
    end else begin
      state       <= state_next;
      meter_valid <= cmd.ld_out || (meter_valid && meter_stall);
    end
  end

endmodule

[sv/spbm_dp.sv]
// ----------------------------------------------------------------------------
// spbm_dp
// Datapath: spring and peak state, one shared 40x24 multiplier with a
// product register, rounding scaler and the result register.
// ----------------------------------------------------------------------------
module spbm_dp (
  input  logic              clk,
  input  logic              rst,
  input  spbm_pkg::cfg_t    cfg,
  input  spbm_pkg::cmd_t    cmd,
  output spbm_pkg::status_t status,
  input  logic [16:0]       level_sample,
  output logic [16:0]       bar_level,
  output logic [16:0]       peak_level,
  output logic [23:0]       peak_speed,
  output logic [14:0]       tail_length
);
  import spbm_pkg::*;

  localparam logic [16:0] ONE_V  = 17'(ONE);
  localparam logic [14:0] CAP_V  = 15'(TAIL_CAP);

  logic signed [17:0] diff;
  logic signed [27:0] spr;
  logic        [16:0] zeta;
  logic signed [39:0] acc;
  logic signed [31:0] vel;
  logic        [16:0] bar;
  logic signed [25:0] peak;
  logic        [23:0] pv;
  logic        [23:0] held;
  logic signed [63:0] prod;

  logic        [16:0] lev_c;
  logic        [16:0] bounce_c;
  logic        [21:0] dz;
  logic signed [39:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] rnd;
  logic signed [63:0] sdv;
  logic signed [41:0] vsum;
  logic signed [31:0] vel_sat;
  logic signed [33:0] bsum;
  logic signed [25:0] bar_s;
  logic        [24:0] held_sum;
  logic        [23:0] held_sat;
  logic        [24:0] psum;
  logic        [14:0] tail_v;

  assign lev_c    = (level_sample > ONE_V) ? ONE_V : level_sample;
  assign bounce_c = (cfg.bounce > ONE_V) ? ONE_V : cfg.bounce;
  assign dz       = 22'(zeta * DAMP_K);

  always_comb begin
    case (cmd.mul_sel)
      MUL_ZETA: begin
        mul_a = $signed({23'b0, bounce_c});
        mul_b = 24'(K_SIX);
      end
      MUL_DAMP: begin
        mul_a = 40'(vel);
        mul_b = $signed({2'b0, dz});
      end
      MUL_ACC: begin
        mul_a = acc;
        mul_b = $signed({8'b0, cfg.step});
      end
      MUL_VEL: begin
        mul_a = 40'(vel);
        mul_b = $signed({8'b0, cfg.step});
      end
      MUL_GRAV: begin
        mul_a = $signed({16'b0, cfg.grav});
        mul_b = $signed({8'b0, cfg.step});
      end
      MUL_PEAK: begin
        mul_a = $signed({16'b0, pv});
        mul_b = $signed({8'b0, cfg.step});
      end
      MUL_TAIL: begin
        mul_a = $signed({16'b0, pv});
        mul_b = 24'(K_TAIL);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half away from zero: bias by one less on negative products
  assign rnd = prod + 64'(HALF) - {63'b0, prod[63]};
  assign sdv = rnd >>> FRAC_BITS;

  assign vsum = 42'(vel) + sdv[41:0];
  always_comb begin
    if (vsum > 42'sd2147483647) begin
      vel_sat = 32'sh7FFFFFFF;
    end else if (vsum < -42'sd2147483648) begin
      vel_sat = 32'sh80000000;
    end else begin
      vel_sat = vsum[31:0];
    end
  end

  assign bsum  = $signed({17'b0, bar}) + sdv[33:0];
  assign bar_s = $signed({9'b0, bar});

  assign held_sum = {1'b0, held} + {9'b0, cfg.step};
  assign held_sat = held_sum[24] ? 24'hFFFFFF : held_sum[23:0];
  assign psum     = {1'b0, pv} + sdv[24:0];
  assign tail_v   = (sdv > 64'(TAIL_CAP)) ? CAP_V : sdv[14:0];

  assign status.follow  = (bar_s >= peak);
  assign status.expired = (held_sat > cfg.hold);

  always_ff @(posedge clk) begin
    if (rst) begin
      vel  <= '0;
      bar  <= '0;
      peak <= '0;
      pv   <= '0;
      held <= '0;
    end else begin
      if (cmd.ld_vel) begin
        vel <= vel_sat;
      end
      if (cmd.ld_bar) begin
        if (bsum < 0) begin
          bar <= '0;
          if (vel < 0) begin
            vel <= '0;
          end
        end else if (bsum > 34'(ONE)) begin
          bar <= ONE_V;
          if (vel > 0) begin
            vel <= '0;
          end
        end else begin
          bar <= bsum[16:0];
        end
      end
      if (cmd.ld_hold) begin
        if (status.follow) begin
          peak <= bar_s;
          pv   <= '0;
          held <= '0;
        end else begin
          held <= held_sat;
        end
      end
      if (cmd.ld_pv) begin
        pv <= psum[24] ? 24'hFFFFFF : psum[23:0];
      end
      if (cmd.ld_drop) begin
        peak <= peak - sdv[25:0];
      end
      if (cmd.ld_snap && (peak < bar_s)) begin
        peak <= bar_s;
        pv   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      diff <= $signed({1'b0, lev_c}) - $signed({1'b0, bar});
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.ld_spr) begin
      spr <= 28'(diff * SPRING_K);
    end
    if (cmd.ld_zeta) begin
      zeta <= ONE_V - sdv[16:0];
    end
    if (cmd.ld_acc) begin
      acc <= 40'(spr) - sdv[39:0];
    end
    if (cmd.ld_out) begin
      bar_level   <= bar;
      peak_level  <= peak[16:0];
      peak_speed  <= pv;
      tail_length <= tail_v;
    end
  end

endmodule

[sv/spring_bar_peak_hold_meter_unit.sv]
// ----------------------------------------------------------------------------
// spring_bar_peak_hold_meter_unit
// Spring-driven level bar with a peak-hold dot that falls under gravity.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  level_sample
//   meter     out        meter_valid / meter_stall    bar_level, peak_level,
//                                                     peak_speed, tail_length
//   config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// A transaction runs through the spring states and the tail state, and the
// gravity and drop states too while the peak falls; all but the spring and
// damping-constant products go through one shared 40x24 multiplier.
// Reset (synchronous, active high) clears bar, velocity, peak and hold
// state and loads the register defaults.
// A stalled result is held in the output register; the next sample is
// taken meanwhile and waits at its last step until that register frees.
// ----------------------------------------------------------------------------
module spring_bar_peak_hold_meter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [16:0]                  level_sample,
  output logic                         meter_valid,
  input  logic                         meter_stall,
  output logic [16:0]                  bar_level,
  output logic [16:0]                  peak_level,
  output logic [23:0]                  peak_speed,
  output logic [14:0]                  tail_length,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spbm_pkg::ADDR_W-1:0]  paddr,
  input  logic [spbm_pkg::DATA_W-1:0]  pwdata,
  output logic [spbm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import spbm_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  spbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spbm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .meter_valid  (meter_valid),
    .meter_stall  (meter_stall),
    .status       (status),
    .cmd          (cmd)
  );

  spbm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .level_sample (level_sample),
    .bar_level    (bar_level),
    .peak_level   (peak_level),
    .peak_speed   (peak_speed),
    .tail_length  (tail_length)
  );

endmodule
